/* rtl/tgaud_pkg.sv */
package tgaud_pkg;

  // Largest accepted width or height.
  localparam int unsigned MAX_DIMENSION = 4096;
  // Pixel counters hold 0 .. MAX_DIMENSION.
  localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam logic [15:0] MAX_DIM_16 = 16'(MAX_DIMENSION);

  localparam int unsigned HDR_LEN   = 18;
  localparam int unsigned HDR_IDX_W = $clog2(HDR_LEN);
  localparam logic [7:0]  HDR_LAST  = 8'(HDR_LEN - 1);

  localparam int unsigned COORD_W = 12;

  localparam logic [7:0]  DEPTH_24      = 8'd24;
  localparam logic [7:0]  DEPTH_32      = 8'd32;
  localparam logic [7:0]  ALPHA_OPAQUE  = 8'hFF;
  localparam logic [15:0] PALETTE_MAX   = 16'd256;
  localparam int unsigned ORIENT_BIT    = 5;
  localparam logic [7:0]  TYPE_MAPPED   = 8'd1;
  localparam logic [7:0]  TYPE_TRUECOL  = 8'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIPID,
    PH_PALETTE,
    PH_PIXELS
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PALETTE,
    KIND_RGBA,
    KIND_INDEX,
    KIND_ERROR
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE,
    ERR_TYPE,
    ERR_DEPTH,
    ERR_MAP,
    ERR_SIZE
  } err_e;

  // Decoded header fields.
  typedef struct packed {
    logic [7:0]  id_len;
    logic        has_map;
    logic [7:0]  img_type;
    logic [15:0] map_origin;
    logic [15:0] map_len;
    logic [7:0]  map_depth;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  pix_depth;
    logic        top_down;
  } hdr_t;

  // Header store write port.
  typedef struct packed {
    logic                 en;
    logic [HDR_IDX_W-1:0] idx;
    logic [7:0]           data;
  } hdr_wr_t;

  typedef struct packed {
    kind_e              kind;
    logic [COORD_W-1:0] column_or_entry;
    logic [COORD_W-1:0] row;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [7:0]         palette_index;
    err_e               error_code;
    logic               last_pixel;
  } res_t;

  function automatic logic [COORD_W-1:0] coord_f(input logic [DIM_W-1:0] v);
    return COORD_W'(v);
  endfunction

endpackage

/* rtl/tga_uncompressed_decoder_top.sv */
// Uncompressed TGA decoder.
//
// Input channel (in_valid_i / in_ready_o): one byte of the TGA file per
// transaction. first_byte_i marks header byte 0 of a new image and restarts
// parsing wherever the decoder was. Bytes outside an image are dropped.
// Output channel (out_valid_o / out_ready_i): at most one result per input
// byte: a palette entry, an RGBA pixel, an indexed pixel or a header error.
// An error stops the image until the next first byte.
//
// Pipeline: an input register, one pass of parse logic, a result register.
// A byte's result is loaded into the result register once that register can
// take it, that is when it is empty or being drained.
// One byte is taken every cycle while the receiver keeps up; throughput is
// one byte per cycle.
// When the receiver stalls, the result register holds and the input register
// still takes one more byte; after that in_ready_o drops until the result is
// taken.
//
// Reset (rst_ni, async, active low) empties both registers and puts the
// parser in idle, waiting for a first byte. The header store and component
// hold registers are not reset; they are always written before use.
module tga_uncompressed_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [11:0] column_or_entry_o,
  output logic [11:0] row_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic [7:0]  palette_index_o,
  output logic [2:0]  error_code_o,
  output logic        last_pixel_o
);

  // Input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       first_q;

  // Result register
  logic            out_valid_q;
  tgaud_pkg::res_t res_q;

  logic               advance, step;
  logic               res_valid;
  tgaud_pkg::res_t    res;
  tgaud_pkg::hdr_t    hdr;
  tgaud_pkg::hdr_wr_t hdr_wr;

  // The result register can be reloaded when empty or being drained.
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign step       = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q  <= data_byte_i;
      first_q <= first_byte_i;
    end
  end

  tgaud_hdr u_hdr (
    .clk_i (clk_i),
    .wr_i  (hdr_wr),
    .hdr_o (hdr)
  );

  tgaud_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (byte_q),
    .first_i     (first_q),
    .hdr_i       (hdr),
    .hdr_wr_o    (hdr_wr),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = res_q.kind;
  assign column_or_entry_o = res_q.column_or_entry;
  assign row_o             = res_q.row;
  assign red_o             = res_q.red;
  assign green_o           = res_q.green;
  assign blue_o            = res_q.blue;
  assign alpha_o           = res_q.alpha;
  assign palette_index_o   = res_q.palette_index;
  assign error_code_o      = res_q.error_code;
  assign last_pixel_o      = res_q.last_pixel;

`ifndef SYNTHESIS
  a_err_code_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind == tgaud_pkg::KIND_ERROR
      |-> res_q.error_code != tgaud_pkg::ERR_NONE)
    else $error("error result without error code");

  a_err_code_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.kind != tgaud_pkg::KIND_ERROR
      |-> res_q.error_code == tgaud_pkg::ERR_NONE)
    else $error("error code on non-error result");

  a_last_on_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.last_pixel
      |-> res_q.kind == tgaud_pkg::KIND_RGBA || res_q.kind == tgaud_pkg::KIND_INDEX)
    else $error("last_pixel on non-pixel result");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while both stages are blocked");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(byte_q) && $stable(first_q))
    else $error("pending input byte lost during stall");
`endif

endmodule

/* rtl/tgaud_hdr.sv */
module tgaud_hdr (
  input  logic               clk_i,
  input  tgaud_pkg::hdr_wr_t wr_i,
  output tgaud_pkg::hdr_t    hdr_o
);

  logic [7:0] hdr_q [tgaud_pkg::HDR_LEN];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      hdr_q[wr_i.idx] <= wr_i.data;
    end
  end

  assign hdr_o.id_len     = hdr_q[0];
  assign hdr_o.has_map    = (hdr_q[1] != 8'd0);
  assign hdr_o.img_type   = hdr_q[2];
  assign hdr_o.map_origin = {hdr_q[4], hdr_q[3]};
  assign hdr_o.map_len    = {hdr_q[6], hdr_q[5]};
  assign hdr_o.map_depth  = hdr_q[7];
  assign hdr_o.width      = {hdr_q[13], hdr_q[12]};
  assign hdr_o.height     = {hdr_q[15], hdr_q[14]};
  assign hdr_o.pix_depth  = hdr_q[16];
  assign hdr_o.top_down   = hdr_q[17][tgaud_pkg::ORIENT_BIT];

endmodule

/* rtl/tgaud_core.sv */
module tgaud_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                first_i,
  input  tgaud_pkg::hdr_t     hdr_i,
  output tgaud_pkg::hdr_wr_t  hdr_wr_o,
  output logic                res_valid_o,
  output tgaud_pkg::res_t     res_o
);

  localparam int unsigned DW = tgaud_pkg::DIM_W;

  tgaud_pkg::phase_e phase_q, phase_d, ph;
  logic [7:0]    bc_q, bc_d, bc, bc_inc, bc_dec;
  logic [8:0]    pal_q, pal_d;
  logic [DW-1:0] col_q, col_d, row_q, row_d;
  logic [1:0]    cnt_q, cnt_d;
  logic [7:0]    hold_q [3];

  // Component collector
  logic          four, coll_done, hold_we;
  logic [1:0]    coll_cnt;
  logic [7:0]    coll_red, coll_alpha;

  // Header check and body start
  tgaud_pkg::err_e   err;
  tgaud_pkg::phase_e pix_ph, body_ph;
  logic [7:0]        chk_depth;

  // Pixel stepping
  logic [DW-1:0] col_inc, row_inc;
  logic [15:0]   dst_row;

  assign ph     = first_i ? tgaud_pkg::PH_HEADER : phase_q;
  assign bc     = first_i ? 8'd0 : bc_q;
  assign bc_inc = bc + 8'd1;
  assign bc_dec = bc - 8'd1;

  assign four = (ph == tgaud_pkg::PH_PALETTE) ? (hdr_i.map_depth == tgaud_pkg::DEPTH_32)
                                              : (hdr_i.pix_depth == tgaud_pkg::DEPTH_32);

  always_comb begin
    hold_we    = 1'b0;
    coll_done  = 1'b0;
    coll_cnt   = cnt_q;
    coll_red   = hold_q[2];
    coll_alpha = byte_i;
    if (cnt_q != 2'd3) begin
      hold_we    = 1'b1;
      coll_cnt   = cnt_q + 2'd1;
      coll_done  = (cnt_q == 2'd2) && !four;
      coll_red   = byte_i;
      coll_alpha = tgaud_pkg::ALPHA_OPAQUE;
    end else begin
      coll_done = 1'b1;
    end
    if (coll_done) begin
      coll_cnt = 2'd0;
    end
  end

  assign chk_depth = hdr_i.has_map ? hdr_i.map_depth : hdr_i.pix_depth;

  always_comb begin
    err = tgaud_pkg::ERR_NONE;
    if (hdr_i.img_type != tgaud_pkg::TYPE_MAPPED && hdr_i.img_type != tgaud_pkg::TYPE_TRUECOL) begin
      err = tgaud_pkg::ERR_TYPE;
    end else if (hdr_i.has_map && hdr_i.map_origin != 16'd0) begin
      err = tgaud_pkg::ERR_MAP;
    end else if (hdr_i.has_map && hdr_i.map_len > tgaud_pkg::PALETTE_MAX) begin
      err = tgaud_pkg::ERR_MAP;
    end else if (chk_depth != tgaud_pkg::DEPTH_24 && chk_depth != tgaud_pkg::DEPTH_32) begin
      err = tgaud_pkg::ERR_DEPTH;
    end else if (hdr_i.width > tgaud_pkg::MAX_DIM_16
                 || hdr_i.height > tgaud_pkg::MAX_DIM_16) begin
      err = tgaud_pkg::ERR_SIZE;
    end
  end

  assign pix_ph  = (hdr_i.width == 16'd0 || hdr_i.height == 16'd0) ? tgaud_pkg::PH_IDLE
                                                                  : tgaud_pkg::PH_PIXELS;
  assign body_ph = (hdr_i.has_map && hdr_i.map_len != 16'd0) ? tgaud_pkg::PH_PALETTE : pix_ph;

  assign col_inc = col_q + DW'(1);
  assign row_inc = row_q + DW'(1);
  assign dst_row = hdr_i.top_down ? 16'(row_q) : (hdr_i.height - 16'd1 - 16'(row_q));

  always_comb begin
    phase_d     = phase_q;
    bc_d        = bc_q;
    pal_d       = pal_q;
    col_d       = col_q;
    row_d       = row_q;
    cnt_d       = cnt_q;
    hdr_wr_o    = '0;
    res_valid_o = 1'b0;
    res_o       = '0;

    case (ph)
      tgaud_pkg::PH_HEADER: begin
        phase_d       = tgaud_pkg::PH_HEADER;
        hdr_wr_o.en   = 1'b1;
        hdr_wr_o.idx  = bc[tgaud_pkg::HDR_IDX_W-1:0];
        hdr_wr_o.data = byte_i;
        bc_d          = bc_inc;
        if (bc == tgaud_pkg::HDR_LAST) begin
          if (err != tgaud_pkg::ERR_NONE) begin
            res_valid_o      = 1'b1;
            res_o.kind       = tgaud_pkg::KIND_ERROR;
            res_o.error_code = err;
            phase_d          = tgaud_pkg::PH_IDLE;
          end else if (hdr_i.id_len != 8'd0) begin
            bc_d    = hdr_i.id_len;
            phase_d = tgaud_pkg::PH_SKIPID;
          end else begin
            phase_d = body_ph;
            pal_d   = '0;
            cnt_d   = '0;
            col_d   = '0;
            row_d   = '0;
          end
        end
      end

      tgaud_pkg::PH_SKIPID: begin
        bc_d = bc_dec;
        if (bc_dec == 8'd0) begin
          phase_d = body_ph;
          pal_d   = '0;
          cnt_d   = '0;
          col_d   = '0;
          row_d   = '0;
        end
      end

      tgaud_pkg::PH_PALETTE: begin
        cnt_d = coll_cnt;
        if (coll_done) begin
          res_valid_o           = 1'b1;
          res_o.kind            = tgaud_pkg::KIND_PALETTE;
          res_o.column_or_entry = tgaud_pkg::COORD_W'(pal_q);
          res_o.red             = coll_red;
          res_o.green           = hold_q[1];
          res_o.blue            = hold_q[0];
          res_o.alpha           = coll_alpha;
          pal_d                 = pal_q + 9'd1;
          if (16'(pal_q) + 16'd1 >= hdr_i.map_len) begin
            phase_d = pix_ph;
            cnt_d   = '0;
            col_d   = '0;
            row_d   = '0;
          end
        end
      end

      tgaud_pkg::PH_PIXELS: begin
        if (!hdr_i.has_map) begin
          cnt_d = coll_cnt;
        end
        if (hdr_i.has_map || coll_done) begin
          res_valid_o           = 1'b1;
          res_o.column_or_entry = tgaud_pkg::coord_f(col_q);
          res_o.row             = dst_row[tgaud_pkg::COORD_W-1:0];
          if (hdr_i.has_map) begin
            res_o.kind          = tgaud_pkg::KIND_INDEX;
            res_o.palette_index = byte_i;
          end else begin
            res_o.kind  = tgaud_pkg::KIND_RGBA;
            res_o.red   = coll_red;
            res_o.green = hold_q[1];
            res_o.blue  = hold_q[0];
            res_o.alpha = coll_alpha;
          end
          col_d = col_inc;
          if (16'(col_inc) >= hdr_i.width) begin
            col_d = '0;
            row_d = row_inc;
            if (16'(row_inc) >= hdr_i.height) begin
              res_o.last_pixel = 1'b1;
              phase_d          = tgaud_pkg::PH_IDLE;
            end
          end
        end
      end

      default: begin
      end
    endcase

    if (!step_i) begin
      hdr_wr_o.en = 1'b0;
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tgaud_pkg::PH_IDLE;
      bc_q    <= '0;
      pal_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      bc_q    <= bc_d;
      pal_q   <= pal_d;
      col_q   <= col_d;
      row_q   <= row_d;
      cnt_q   <= cnt_d;
    end
  end

  // Component hold bytes are payload: no reset.
  always_ff @(posedge clk_i) begin
    if (step_i && hold_we
        && (ph == tgaud_pkg::PH_PALETTE || (ph == tgaud_pkg::PH_PIXELS && !hdr_i.has_map))) begin
      hold_q[cnt_q] <= byte_i;
    end
  end

endmodule

/* tb/tga_uncompressed_decoder_top_tb.sv */
`timescale 1ns / 100ps

module tga_uncompressed_decoder_top_tb;
  import tgaud_pkg::*;

  // Byte offsets inside the 18-byte TGA header.
  localparam int HB_ID_LEN     = 0;
  localparam int HB_MAP_TYPE   = 1;
  localparam int HB_TYPE       = 2;
  localparam int HB_MAP_ORIGIN = 3;
  localparam int HB_MAP_LEN    = 5;
  localparam int HB_MAP_DEPTH  = 7;
  localparam int HB_WIDTH      = 12;
  localparam int HB_HEIGHT     = 14;
  localparam int HB_PIX_DEPTH  = 16;
  localparam int HB_DESC       = 17;

  // Results come out after their byte passes the input and result registers;
  // the drain time also covers bytes still inside the pipeline that produce nothing.
  localparam int DRAIN_CYCLES = 10;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } file_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        first_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [11:0] column_or_entry_o;
  logic [11:0] row_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  alpha_o;
  logic [7:0]  palette_index_o;
  logic [2:0]  error_code_o;
  logic        last_pixel_o;

  tga_uncompressed_decoder_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .first_byte_i      (first_byte_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .column_or_entry_o (column_or_entry_o),
    .row_o             (row_o),
    .red_o             (red_o),
    .green_o           (green_o),
    .blue_o            (blue_o),
    .alpha_o           (alpha_o),
    .palette_index_o   (palette_index_o),
    .error_code_o      (error_code_o),
    .last_pixel_o      (last_pixel_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Bytes waiting to be sent, and the decoded results still owed by the DUT.
  file_byte_t  file_bytes[$];
  res_t        expected_results[$];
  int unsigned bytes_queued = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // Idle rates (percent of cycles) and the long receiver hold-off request.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;
  logic        byte_taken = 1'b0;

  // ---------------------------------------------------------------------------
  // Decoder predictor: its own copy of the parse state, updated per accepted
  // byte. Reset state is the declaration value (idle, counters zero).
  // ---------------------------------------------------------------------------
  phase_e      dec_phase = PH_IDLE;
  logic [7:0]  dec_count = '0;     // header index, then ID bytes left to skip
  logic [7:0]  dec_hdr [HDR_LEN];
  logic [15:0] dec_entry = '0;
  logic [15:0] dec_col = '0;
  logic [15:0] dec_row = '0;
  logic [7:0]  dec_comp [3];
  logic [1:0]  dec_ncomp = '0;

  function automatic logic [15:0] hdr_word(input int idx);
    return {dec_hdr[idx+1], dec_hdr[idx]};
  endfunction

  task automatic enter_pixels();
    dec_col = '0;
    dec_row = '0;
    dec_ncomp = '0;
    // Zero width or height: the image ends here, nothing more to emit.
    if (hdr_word(HB_WIDTH) == 16'd0 || hdr_word(HB_HEIGHT) == 16'd0)
      dec_phase = PH_IDLE;
    else
      dec_phase = PH_PIXELS;
  endtask

  task automatic enter_body();
    dec_entry = '0;
    dec_ncomp = '0;
    if (dec_hdr[HB_MAP_TYPE] != 8'd0 && hdr_word(HB_MAP_LEN) != 16'd0)
      dec_phase = PH_PALETTE;
    else
      enter_pixels();
  endtask

  // Collects B, G, R (and A when four) bytes; done marks a complete color.
  task automatic gather(input logic [7:0] b, input logic four, inout res_t r,
                        output logic done);
    done = 1'b0;
    if (dec_ncomp < 2'd3) begin
      dec_comp[dec_ncomp] = b;
      dec_ncomp++;
      if (dec_ncomp == 2'd3 && !four) begin
        r.alpha = ALPHA_OPAQUE;
        done = 1'b1;
      end
    end else begin
      r.alpha = b;
      done = 1'b1;
    end
    if (done) begin
      dec_ncomp = '0;
      r.red = dec_comp[2];
      r.green = dec_comp[1];
      r.blue = dec_comp[0];
    end
  endtask

  task automatic place_pixel(input kind_e k, inout res_t r);
    logic [15:0] w, h, dst;
    w = hdr_word(HB_WIDTH);
    h = hdr_word(HB_HEIGHT);
    // Bottom-up images (orientation bit clear) land flipped.
    dst = dec_hdr[HB_DESC][ORIENT_BIT] ? dec_row : h - 16'd1 - dec_row;
    r.kind = k;
    r.column_or_entry = dec_col[11:0];
    r.row = dst[11:0];
    dec_col++;
    if (dec_col >= w) begin
      dec_col = '0;
      dec_row++;
      if (dec_row >= h) begin
        r.last_pixel = 1'b1;
        dec_phase = PH_IDLE;
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic first);
    res_t       want;
    logic       emit;
    logic       done;
    logic       has_map;
    logic [7:0] depth;
    err_e       code;
    want = '0;
    emit = 1'b0;
    if (first) begin
      dec_phase = PH_HEADER;
      dec_count = '0;
    end
    case (dec_phase)
      PH_HEADER: begin
        dec_hdr[dec_count] = b;
        dec_count++;
        if (dec_count == HDR_LEN) begin
          // Checks in priority order; the first failing one wins.
          has_map = dec_hdr[HB_MAP_TYPE] != 8'd0;
          depth = has_map ? dec_hdr[HB_MAP_DEPTH] : dec_hdr[HB_PIX_DEPTH];
          code = ERR_NONE;
          if (dec_hdr[HB_TYPE] != TYPE_MAPPED && dec_hdr[HB_TYPE] != TYPE_TRUECOL)
            code = ERR_TYPE;
          else if (has_map && hdr_word(HB_MAP_ORIGIN) != 16'd0)
            code = ERR_MAP;
          else if (has_map && hdr_word(HB_MAP_LEN) > PALETTE_MAX)
            code = ERR_MAP;
          else if (depth != DEPTH_24 && depth != DEPTH_32)
            code = ERR_DEPTH;
          else if (hdr_word(HB_WIDTH) > MAX_DIM_16 || hdr_word(HB_HEIGHT) > MAX_DIM_16)
            code = ERR_SIZE;
          if (code != ERR_NONE) begin
            want.kind = KIND_ERROR;
            want.error_code = code;
            emit = 1'b1;
            dec_phase = PH_IDLE;
          end else if (dec_hdr[HB_ID_LEN] != 8'd0) begin
            dec_count = dec_hdr[HB_ID_LEN];
            dec_phase = PH_SKIPID;
          end else begin
            enter_body();
          end
        end
      end
      PH_SKIPID: begin
        dec_count--;
        if (dec_count == 8'd0) enter_body();
      end
      PH_PALETTE: begin
        gather(b, dec_hdr[HB_MAP_DEPTH] == DEPTH_32, want, done);
        if (done) begin
          want.kind = KIND_PALETTE;
          want.column_or_entry = dec_entry[11:0];
          emit = 1'b1;
          dec_entry++;
          if (dec_entry >= hdr_word(HB_MAP_LEN)) enter_pixels();
        end
      end
      PH_PIXELS: begin
        // A color map means index pixels, whatever the image type says.
        if (dec_hdr[HB_MAP_TYPE] != 8'd0) begin
          want.palette_index = b;
          place_pixel(KIND_INDEX, want);
          emit = 1'b1;
        end else begin
          gather(b, dec_hdr[HB_PIX_DEPTH] == DEPTH_32, want, done);
          if (done) begin
            place_pixel(KIND_RGBA, want);
            emit = 1'b1;
          end
        end
      end
      default: ;  // idle: byte dropped
    endcase
    if (emit) expected_results.push_back(want);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents the head of file_bytes, holds it until the transaction
  // completes. Inputs move on the falling edge only.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || byte_taken) begin
      if (file_bytes.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_valid_i   <= 1'b1;
        data_byte_i  <= file_bytes[0].data;
        first_byte_i <= file_bytes[0].first;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // Input side monitor: every accepted byte goes through the predictor.
  always @(posedge clk_i) begin
    byte_taken = rst_ni && in_valid_i && in_ready_o;
    if (byte_taken) begin
      void'(file_bytes.pop_front());
      decode_byte(data_byte_i, first_byte_i);
    end
  end

  function automatic void check_field(input string name, input logic [11:0] want,
                                      input logic [11:0] got);
    if (want !== got) $error("%s: expected %0d, got %0d", name, want, got);
  endfunction

  // Output side monitor: in-order compare against the oldest expectation.
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind = kind_e'(kind_o);
      got.column_or_entry = column_or_entry_o;
      got.row = row_o;
      got.red = red_o;
      got.green = green_o;
      got.blue = blue_o;
      got.alpha = alpha_o;
      got.palette_index = palette_index_o;
      got.error_code = err_e'(error_code_o);
      got.last_pixel = last_pixel_o;
      if (expected_results.size() == 0) begin
        fail_count++;
        $error("unexpected result: kind %0d, column %0d, row %0d", kind_o,
               column_or_entry_o, row_o);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          fail_count++;
          check_field("kind", want.kind, got.kind);
          check_field("column_or_entry", want.column_or_entry, got.column_or_entry);
          check_field("row", want.row, got.row);
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("alpha", want.alpha, got.alpha);
          check_field("palette_index", want.palette_index, got.palette_index);
          check_field("error_code", want.error_code, got.error_code);
          check_field("last_pixel", want.last_pixel, got.last_pixel);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: TGA files built byte by byte into file_bytes.
  // ---------------------------------------------------------------------------
  logic [7:0] img_hdr [HDR_LEN];

  task automatic push_byte(input logic [7:0] b, input logic first);
    file_bytes.push_back('{data: b, first: first});
    bytes_queued++;
  endtask

  task automatic set_word(input int idx, input int val);
    img_hdr[idx]   = 8'(val);
    img_hdr[idx+1] = 8'(val >> 8);
  endtask

  // Fields not named here (x/y origin) get random bytes.
  task automatic set_header(input int id_len, map_type, img_type, map_org, map_len,
                            map_depth, width, height, pix_depth, desc);
    foreach (img_hdr[i]) img_hdr[i] = 8'($urandom);
    img_hdr[HB_ID_LEN]    = 8'(id_len);
    img_hdr[HB_MAP_TYPE]  = 8'(map_type);
    img_hdr[HB_TYPE]      = 8'(img_type);
    set_word(HB_MAP_ORIGIN, map_org);
    set_word(HB_MAP_LEN, map_len);
    img_hdr[HB_MAP_DEPTH] = 8'(map_depth);
    set_word(HB_WIDTH, width);
    set_word(HB_HEIGHT, height);
    img_hdr[HB_PIX_DEPTH] = 8'(pix_depth);
    img_hdr[HB_DESC]      = 8'(desc);
  endtask

  // Sends hdr_bytes of img_hdr; with_body adds ID, palette and pixel bytes
  // (minus cut from the end), then junk bytes without a first marker.
  task automatic push_image(input int hdr_bytes, input bit with_body, input int cut,
                            input int junk);
    int   n, per_entry, per_px;
    logic map;
    for (int i = 0; i < hdr_bytes; i++) push_byte(img_hdr[i], i == 0);
    if (with_body) begin
      map = img_hdr[HB_MAP_TYPE] != 8'd0;
      per_entry = (img_hdr[HB_MAP_DEPTH] == DEPTH_32) ? 4 : 3;
      per_px = map ? 1 : ((img_hdr[HB_PIX_DEPTH] == DEPTH_32) ? 4 : 3);
      n = int'(img_hdr[HB_ID_LEN])
        + (map ? per_entry * int'({img_hdr[HB_MAP_LEN+1], img_hdr[HB_MAP_LEN]}) : 0)
        + per_px * int'({img_hdr[HB_WIDTH+1], img_hdr[HB_WIDTH]})
                 * int'({img_hdr[HB_HEIGHT+1], img_hdr[HB_HEIGHT]});
      n = (n > cut) ? n - cut : 0;
      repeat (n) push_byte(8'($urandom), 1'b0);
    end
    repeat (junk) push_byte(8'($urandom), 1'b0);
  endtask

  task automatic push_random_image();
    int         pick, w, h, mlen, id_len, cut, junk;
    logic       map;
    logic [7:0] depth_m, depth_p, bad;
    pick = $urandom_range(99, 0);
    map = 1'($urandom_range(1, 0));
    depth_m = $urandom_range(1, 0) ? DEPTH_32 : DEPTH_24;
    depth_p = $urandom_range(1, 0) ? DEPTH_32 : DEPTH_24;
    mlen = ($urandom_range(29, 0) == 0) ? $urandom_range(256, 128) : $urandom_range(6, 0);
    w = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(6, 1);
    h = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(5, 1);
    id_len = ($urandom_range(3, 0) == 0) ? $urandom_range(4, 1) : 0;
    // Map fields are don't-care without a map, and pixel depth with one.
    set_header(id_len, map ? $urandom_range(255, 1) : 0,
               $urandom_range(1, 0) ? TYPE_MAPPED : TYPE_TRUECOL,
               map ? 0 : $urandom_range(65535, 0),
               map ? mlen : $urandom_range(65535, 0),
               map ? depth_m : $urandom_range(255, 0),
               w, h, map ? $urandom_range(255, 0) : depth_p, $urandom_range(255, 0));
    if (pick < 70) begin
      // Well-formed image, sometimes cut short by the next first byte.
      cut = ($urandom_range(7, 0) == 0) ? $urandom_range(6, 1) : 0;
      junk = ($urandom_range(4, 0) == 0) ? $urandom_range(3, 1) : 0;
      push_image(HDR_LEN, 1'b1, cut, junk);
    end else if (pick < 85) begin
      // One chosen header fault; a map turned on here keeps its random map fields.
      case ($urandom_range(4, 0))
        0: img_hdr[HB_TYPE] = $urandom_range(1, 0) ? 8'd0 : 8'($urandom_range(255, 3));
        1: begin
          if (img_hdr[HB_MAP_TYPE] == 8'd0) img_hdr[HB_MAP_TYPE] = 8'd1;
          set_word(HB_MAP_ORIGIN, $urandom_range(65535, 1));
        end
        2: begin
          if (img_hdr[HB_MAP_TYPE] == 8'd0) img_hdr[HB_MAP_TYPE] = 8'd1;
          set_word(HB_MAP_ORIGIN, 0);
          set_word(HB_MAP_LEN, $urandom_range(65535, 257));
        end
        3: begin
          do bad = 8'($urandom); while (bad == DEPTH_24 || bad == DEPTH_32);
          if (img_hdr[HB_MAP_TYPE] != 8'd0) img_hdr[HB_MAP_DEPTH] = bad;
          else img_hdr[HB_PIX_DEPTH] = bad;
        end
        default: set_word($urandom_range(1, 0) ? HB_WIDTH : HB_HEIGHT,
                          $urandom_range(65535, 4097));
      endcase
      push_image(HDR_LEN, 1'b0, 0, $urandom_range(3, 0));
    end else if (pick < 92) begin
      // Noise header: random bytes throughout.
      foreach (img_hdr[i]) img_hdr[i] = 8'($urandom);
      push_image(HDR_LEN, 1'b0, 0, $urandom_range(4, 0));
    end else if (pick < 96) begin
      // Header cut short; the next first byte, if any, restarts parsing.
      push_image($urandom_range(17, 1), 1'b0, 0, 0);
    end else begin
      repeat ($urandom_range(3, 1)) push_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic random_images(input int unsigned count);
    int unsigned stop_at;
    stop_at = bytes_queued + count;
    while (bytes_queued < stop_at) push_random_image();
  endtask

  // Sender holds back until every byte is in and every result is out.
  task automatic drain();
    while (file_bytes.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    send_idle_pct = 18;
    recv_idle_pct = 87;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: formats, orientation, empty images, restarts, every error.
    set_header(0, 0, TYPE_TRUECOL, 0, 0, 0, 2, 2, DEPTH_24, 8'h00);
    push_image(HDR_LEN, 1'b1, 0, 0);
    set_header(3, 0, TYPE_TRUECOL, 0, 0, 0, 3, 1, DEPTH_32, 8'h20);
    push_image(HDR_LEN, 1'b1, 0, 0);
    set_header(0, 1, TYPE_MAPPED, 0, 3, DEPTH_24, 2, 2, 0, 8'h00);
    push_image(HDR_LEN, 1'b1, 0, 0);
    set_header(0, 1, TYPE_MAPPED, 0, 2, DEPTH_32, 1, 3, 0, 8'hFF);
    push_image(HDR_LEN, 1'b1, 0, 0);
    // Map present with a true-color type: still indexed pixels.
    set_header(1, 1, TYPE_TRUECOL, 0, 1, DEPTH_24, 2, 1, DEPTH_24, 8'h00);
    push_image(HDR_LEN, 1'b1, 0, 0);
    // Zero-length map: straight to index pixels.
    set_header(0, 255, TYPE_MAPPED, 0, 0, DEPTH_24, 1, 2, DEPTH_32, 8'h00);
    push_image(HDR_LEN, 1'b1, 0, 0);
    // Zero width after a palette, zero height without one; trailing bytes dropped.
    set_header(0, 1, TYPE_MAPPED, 0, 2, DEPTH_24, 0, 3, 0, 8'h00);
    push_image(HDR_LEN, 1'b1, 0, 3);
    set_header(0, 0, TYPE_TRUECOL, 0, 0, 0, 4, 0, DEPTH_32, 8'h00);
    push_image(HDR_LEN, 1'b1, 0, 2);
    // Restart in the middle of pixels, then in the middle of a header.
    set_header(0, 0, TYPE_TRUECOL, 0, 0, 0, 3, 3, DEPTH_24, 8'h20);
    push_image(HDR_LEN, 1'b1, 14, 0);
    push_image(9, 1'b0, 0, 0);
    // Header errors, including several faults at once to check priority.
    set_header(0, 0, 0, 0, 0, 0, 1, 1, DEPTH_24, 8'h00);
    push_image(HDR_LEN, 1'b0, 0, 2);
    set_header(0, 1, 255, 5, 300, 16, 1, 1, 0, 8'h00);
    push_image(HDR_LEN, 1'b0, 0, 0);
    set_header(0, 1, TYPE_MAPPED, 16'hFF00, 300, 16, 1, 1, 0, 8'h00);
    push_image(HDR_LEN, 1'b0, 0, 1);
    set_header(0, 1, TYPE_MAPPED, 0, 257, 16, 1, 1, 0, 8'h00);
    push_image(HDR_LEN, 1'b0, 0, 0);
    set_header(0, 1, TYPE_MAPPED, 0, 4, 16, 5000, 1, DEPTH_24, 8'h00);
    push_image(HDR_LEN, 1'b0, 0, 0);
    set_header(0, 0, TYPE_TRUECOL, 0, 0, DEPTH_24, 1, 1, 8, 8'h00);
    push_image(HDR_LEN, 1'b0, 0, 0);
    set_header(0, 0, TYPE_TRUECOL, 0, 0, 0, 4097, 1, DEPTH_32, 8'h00);
    push_image(HDR_LEN, 1'b0, 0, 0);
    set_header(0, 0, TYPE_MAPPED, 0, 0, 0, 1, 65535, DEPTH_24, 8'h20);
    push_image(HDR_LEN, 1'b0, 0, 0);
    // Largest palette, cut short after its first entries, and longest ID field.
    set_header(0, 1, TYPE_MAPPED, 0, 256, DEPTH_24, 1, 1, 0, 8'h00);
    push_image(HDR_LEN, 1'b1, 709, 0);
    set_header(255, 0, TYPE_TRUECOL, 0, 0, 0, 1, 1, DEPTH_24, 8'h00);
    push_image(HDR_LEN, 1'b1, 0, 0);
    drain();

    random_images(250);
    drain();

    send_idle_pct = 87;
    recv_idle_pct = 18;
    random_images(250);
    drain();

    // Full speed; the long hold-off backs the pipeline up onto the sender.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_images(250);
    hold_req = 1'b1;
    // Largest width and height, each cut short after a few pixels.
    set_header(0, 1, TYPE_MAPPED, 0, 1, DEPTH_32, 4096, 1, 0, 8'h20);
    push_image(HDR_LEN, 1'b1, 4092, 0);
    set_header(0, 1, TYPE_MAPPED, 0, 1, DEPTH_24, 1, 4096, 0, 8'h00);
    push_image(HDR_LEN, 1'b1, 4090, 0);
    drain();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/tgaud_pkg.sv
rtl/tgaud_hdr.sv
rtl/tgaud_core.sv
rtl/tga_uncompressed_decoder_top.sv
tb/tga_uncompressed_decoder_top_tb.sv
